@@ hdl/slsi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsi_pkg
// Types and constants shared by the sorted list insert / delete block.
// ----------------------------------------------------------------------------
package slsi_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;
	localparam int COUNT_W   = 5;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_DELETE = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DELETED   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic                    req_type;
		logic signed [VAL_W-1:0] value;
	} req_word_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [COUNT_W-1:0]      count;
		logic                    is_empty_flag;
		logic signed [VAL_W-1:0] smallest;
	} rsp_word_t;

	// passed from each cell to its right neighbor
	typedef struct packed {
		logic gt;   // occupied and holds a value above the request
		logic hit;  // an equal entry sits here or further left
		logic occ;  // cell occupied
	} link_t;

endpackage

@@ hdl/sorted_list_insert_delete.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Sorted store of signed values kept in a chain of cells; each request
// inserts or deletes one value and returns status, count and smallest value.
// ----------------------------------------------------------------------------
//  channel  signals                    word
//  request  req_valid / req_ready      req (req_type, value)
//  response rsp_valid / rsp_ready      rsp (status, count, is_empty_flag, smallest)
//
//  one request per cycle while the response is not stalled; its response appears the cycle after acceptance
//  all cells compare together; when the store changes they all shift together in the accepting cycle
//  the compare / hit chain across DEPTH cells sets the clock period
//  reset empties the store at once; entries themselves are not cleared
//  a stalled response holds the request side only while the output is full
// ----------------------------------------------------------------------------
module sorted_list_insert_delete #(
	parameter int DEPTH = slsi_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  slsi_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output slsi_pkg::rsp_word_t rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  count_d;
	logic                              accept;
	logic                              full;
	logic                              found;
	logic                              cell_en;
	logic [1:0]                        status;
	slsi_pkg::link_t                   links [0:DEPTH];
	logic signed [slsi_pkg::VAL_W-1:0] cur_vals [0:DEPTH-1];
	logic signed [slsi_pkg::VAL_W-1:0] nxt_vals [0:DEPTH-1];
	logic                              rsp_valid_q;
	slsi_pkg::rsp_word_t               rsp_q;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign found     = links[DEPTH].hit;

	assign links[0] = '{gt: 1'b0, hit: 1'b0, occ: 1'b1};

	always_comb begin
		if (req.req_type == slsi_pkg::REQ_INSERT) begin
			cell_en = accept && !full;
			status  = full ? slsi_pkg::ST_FULL : slsi_pkg::ST_INSERTED;
			count_d = full ? count_q : count_q + CNT_W'(1);
		end else begin
			cell_en = accept && found;
			status  = found ? slsi_pkg::ST_DELETED : slsi_pkg::ST_NOT_FOUND;
			count_d = found ? count_q - CNT_W'(1) : count_q;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		slsi_cell u_cell (
			.clk       (clk),
			.en        (cell_en),
			.op        (req.req_type),
			.val       (req.value),
			.occupied  (count_q > CNT_W'(i)),
			.prev_link (links[i]),
			.prev_val  ((i == 0) ? req.value : cur_vals[(i == 0) ? 0 : i - 1]),
			.next_val  ((i == DEPTH - 1) ? cur_vals[i]
			                             : cur_vals[(i == DEPTH - 1) ? i : i + 1]),
			.link      (links[i+1]),
			.cur_val   (cur_vals[i]),
			.nxt_val   (nxt_vals[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status        <= status;
			rsp_q.count         <= slsi_pkg::COUNT_W'(count_d);
			rsp_q.is_empty_flag <= (count_d == '0);
			rsp_q.smallest      <= (count_d == '0) ? '0
			                       : (cell_en ? nxt_vals[0] : cur_vals[0]);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ hdl/slsi_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsi_cell
// One position of the sorted chain: compares against the request and takes
// its next value from itself, the request or a neighbor.
// ----------------------------------------------------------------------------
module slsi_cell (
	input  logic                             clk,
	input  logic                             en,
	input  logic                             op,
	input  logic signed [slsi_pkg::VAL_W-1:0] val,
	input  logic                             occupied,
	input  slsi_pkg::link_t                  prev_link,
	input  logic signed [slsi_pkg::VAL_W-1:0] prev_val,
	input  logic signed [slsi_pkg::VAL_W-1:0] next_val,
	output slsi_pkg::link_t                  link,
	output logic signed [slsi_pkg::VAL_W-1:0] cur_val,
	output logic signed [slsi_pkg::VAL_W-1:0] nxt_val
);

	logic signed [slsi_pkg::VAL_W-1:0] entry_q;
	logic                              gt;
	logic                              hit;
	logic                              ins_here;

	assign gt       = occupied && (val < entry_q);
	assign hit      = prev_link.hit || (occupied && (entry_q == val));
	assign ins_here = !prev_link.gt && (gt || (!occupied && prev_link.occ));

	assign link    = '{gt: gt, hit: hit, occ: occupied};
	assign cur_val = entry_q;

	always_comb begin
		if (op == slsi_pkg::REQ_INSERT) begin
			if (prev_link.gt) begin
				nxt_val = prev_val;
			end else if (ins_here) begin
				nxt_val = val;
			end else begin
				nxt_val = entry_q;
			end
		end else begin
			nxt_val = hit ? next_val : entry_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			entry_q <= nxt_val;
		end
	end

endmodule

@@ hdl/slsi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsi_checker
// Port-level checks for the sorted list insert / delete block.
// ----------------------------------------------------------------------------
module slsi_checker #(
	parameter int DEPTH = slsi_pkg::DEPTH_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input slsi_pkg::req_word_t req,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input slsi_pkg::rsp_word_t rsp
);

	// held response word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// empty store reports zero as smallest
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty_flag |-> rsp.smallest == '0)
		else $error("empty store with nonzero smallest");

	// a successful insert leaves the store nonempty
	a_ins_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == slsi_pkg::ST_INSERTED |-> !rsp.is_empty_flag)
		else $error("insert reported an empty store");

	// a dropped insert only happens at full depth
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == slsi_pkg::ST_FULL
		|-> rsp.count == slsi_pkg::COUNT_W'(DEPTH))
		else $error("full status below full depth");

	// a word accepted at a ready input shows a response next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted request without response");

endmodule

bind sorted_list_insert_delete slsi_checker #(.DEPTH(DEPTH)) u_slsi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

@@ bench/slsi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsi_scoreboard
// Watches both channels of the sorted list block. Each accepted request word
// is run through a shadow copy of the sorted store to predict its response
// word. Each accepted response word is compared field by field against the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module slsi_scoreboard #(
	parameter int DEPTH = slsi_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  slsi_pkg::req_word_t req,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  slsi_pkg::rsp_word_t rsp,
	output int                  fails,
	output int                  pending
);

	logic signed [slsi_pkg::VAL_W-1:0] held [DEPTH];
	int                                held_count;
	slsi_pkg::rsp_word_t               predicted_rsp [$];

	function automatic slsi_pkg::rsp_word_t apply_request(input slsi_pkg::req_word_t w);
		slsi_pkg::rsp_word_t               r;
		logic signed [slsi_pkg::VAL_W-1:0] v;
		int                                pos;
		int                                i;
		v = $signed(w.value);
		pos = held_count;
		if (slsi_pkg::req_kind_t'(w.req_type) == slsi_pkg::REQ_INSERT) begin
			if (held_count >= DEPTH) begin
				r.status = slsi_pkg::ST_FULL;
			end else begin
				// goes after any equal entries
				for (i = 0; i < held_count; i++)
					if (pos == held_count && held[i] > v)
						pos = i;
				for (i = held_count; i > pos; i--)
					held[i] = held[i-1];
				held[pos] = v;
				held_count++;
				r.status = slsi_pkg::ST_INSERTED;
			end
		end else begin
			for (i = 0; i < held_count; i++)
				if (pos == held_count && held[i] == v)
					pos = i;
			if (pos < held_count) begin
				for (i = pos; i + 1 < held_count; i++)
					held[i] = held[i+1];
				held_count--;
				r.status = slsi_pkg::ST_DELETED;
			end else begin
				r.status = slsi_pkg::ST_NOT_FOUND;
			end
		end
		r.count = held_count[slsi_pkg::COUNT_W-1:0];
		r.is_empty_flag = (held_count == 0);
		r.smallest = (held_count == 0) ? '0 : held[0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		slsi_pkg::rsp_word_t want;
		if (!arst_n) begin
			held_count = 0;
			predicted_rsp.delete();
			fails = 0;
			pending = 0;
		end else begin
			// response first: it belongs to an earlier request word
			if (rsp_valid && rsp_ready) begin
				if (predicted_rsp.size() == 0) begin
					$error("response word with no request waiting");
					fails++;
				end else begin
					want = predicted_rsp.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fails++;
					end
					if (rsp.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, rsp.count);
						fails++;
					end
					if (rsp.is_empty_flag !== want.is_empty_flag) begin
						$error("is_empty_flag: expected %0d, got %0d",
							want.is_empty_flag, rsp.is_empty_flag);
						fails++;
					end
					if (rsp.smallest !== want.smallest) begin
						$error("smallest: expected %0d, got %0d",
							$signed(want.smallest), $signed(rsp.smallest));
						fails++;
					end
				end
			end
			if (req_valid && req_ready)
				predicted_rsp.push_back(apply_request(req));
			pending = predicted_rsp.size();
		end
	end

endmodule

@@ bench/sorted_list_insert_delete_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_test
// Drives insert and delete requests into the sorted list block: a directed
// run over the value extremes, duplicates, misses, an empty and a full store,
// then random requests drawn mostly from a small value pool so that deletes
// hit and the store swings between empty and full. Both channels idle at
// random; a scoreboard beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_test;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int POOL_N       = 8;
	localparam int PHASE_ITEMS  = 583;
	localparam int LONG_HOLD    = 250;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	slsi_pkg::req_word_t req;
	logic                rsp_valid;
	logic                rsp_ready;
	slsi_pkg::rsp_word_t rsp;

	int fails;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_asked;
	int hold_done;
	int hold_left;
	int cycle_count;

	logic signed [slsi_pkg::VAL_W-1:0] value_pool [POOL_N];

	sorted_list_insert_delete dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	slsi_scoreboard u_scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.fails     (fails),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sorted_list_insert_delete: mismatch");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off when asked
	always @(negedge clk) begin
		if (hold_asked != hold_done) begin
			hold_done <= hold_done + 1;
			hold_left <= LONG_HOLD;
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_word(input slsi_pkg::req_kind_t kind,
			input logic signed [slsi_pkg::VAL_W-1:0] v);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req.req_type <= kind;
		req.value <= v;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	task automatic drain;
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic refill_pool;
		int k;
		for (k = 0; k < POOL_N; k++) begin
			case ($urandom_range(5))
				0: value_pool[k] = 32'sh7fffffff;
				1: value_pool[k] = 32'sh80000000;
				2: value_pool[k] = $urandom_range(8) - 4;
				default: value_pool[k] = $urandom;
			endcase
		end
	endtask

	function automatic logic signed [slsi_pkg::VAL_W-1:0] pick_value;
		int pick;
		pick = $urandom_range(9);
		if (pick < 6)
			return value_pool[$urandom_range(POOL_N-1)];
		else if (pick < 8)
			return $urandom;
		else
			return $urandom_range(8) - 4;
	endfunction

	initial begin
		int phase;
		int n;
		int k;
		int insert_pct;
		slsi_pkg::req_kind_t kind;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_asked = 0;
		hold_done = 0;
		hold_left = 0;
		cycle_count = 0;
		insert_pct = 50;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty delete, extremes, duplicates, miss, full store
		send_idle_pct = 35;
		recv_idle_pct = 86;
		send_word(slsi_pkg::REQ_DELETE, 0);
		send_word(slsi_pkg::REQ_INSERT, 32'sh7fffffff);
		send_word(slsi_pkg::REQ_INSERT, 32'sh80000000);
		send_word(slsi_pkg::REQ_INSERT, 0);
		send_word(slsi_pkg::REQ_INSERT, -1);
		send_word(slsi_pkg::REQ_INSERT, 5);
		send_word(slsi_pkg::REQ_INSERT, 5);
		send_word(slsi_pkg::REQ_DELETE, 5);
		send_word(slsi_pkg::REQ_DELETE, 123);
		for (k = 0; k < 11; k++)
			send_word(slsi_pkg::REQ_INSERT, k * 7 - 30);
		send_word(slsi_pkg::REQ_INSERT, 1);
		send_word(slsi_pkg::REQ_DELETE, 32'sh7fffffff);
		send_word(slsi_pkg::REQ_DELETE, 32'sh80000000);
		drain();

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 35;
					recv_idle_pct = 86;
				end
				1: begin
					send_idle_pct = 86;
					recv_idle_pct = 35;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0) begin
					refill_pool();
					case ($urandom_range(3))
						0: insert_pct = 20;
						1: insert_pct = 50;
						2: insert_pct = 65;
						default: insert_pct = 85;
					endcase
				end
				if (n == 200 && phase != 1)
					hold_asked = hold_asked + 1;
				kind = ($urandom_range(99) < insert_pct) ? slsi_pkg::REQ_INSERT
				                                         : slsi_pkg::REQ_DELETE;
				send_word(kind, pick_value());
			end
			drain();
		end

		repeat (20) @(negedge clk);
		if (fails == 0)
			$display("sorted_list_insert_delete: match");
		else
			$display("sorted_list_insert_delete: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/slsi_pkg.sv
hdl/slsi_cell.sv
hdl/sorted_list_insert_delete.sv
hdl/slsi_checker.sv
bench/slsi_checker.sv
bench/sorted_list_insert_delete_test.sv
